### src/tssp_pkg.sv
// tssp_pkg: shared types and constants of the two servo scan pwm block
// no dependencies; used by the interfaces and imported by every module
`default_nettype none

package tssp_pkg;

  localparam int unsigned PositionBits = 10;
  localparam int unsigned OffsetBits   = PositionBits - 1;
  localparam int unsigned WriteBits    = 16;
  localparam int unsigned CfgIdxBits   = 2;

  typedef logic [PositionBits-1:0] pos_t;
  typedef logic [OffsetBits-1:0]   off_t;
  typedef logic [CfgIdxBits-1:0]   cfg_idx_t;

  localparam pos_t PosMin    = '0;
  localparam pos_t PosMax    = '1;
  localparam off_t OffsetRst = OffsetBits'(32);

  typedef enum logic [2:0] {
    OpRead     = 3'd0,
    OpStepUp   = 3'd1,
    OpStepDown = 3'd2,
    OpWrite    = 3'd3,
    OpWave     = 3'd4
  } op_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgMinPos  = 2'd0,
    CfgMaxPos  = 2'd1,
    CfgWaveOff = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]                  opcode;
    logic                        servo_select;
    logic signed [WriteBits-1:0] write_value;
    logic                        pwm_ticks;
  } item_t;

  typedef struct packed {
    pos_t min_position;
    pos_t max_position;
    off_t wave_offset;
  } cfg_t;

  typedef struct packed {
    pos_t pos_a;
    pos_t pos_b;
    logic sense_a_down;
    logic sense_b_down;
    logic centers_taken;
    pos_t pwm_count;
  } ctrl_state_t;

  typedef struct packed {
    pos_t center_a;
    pos_t center_b;
  } centers_t;

  typedef struct packed {
    pos_t reply_value;
    pos_t position_a;
    pos_t position_b;
    logic pwm_a;
    logic pwm_b;
  } result_t;

endpackage

`default_nettype wire

### src/tssp_if.sv
// tssp_if: valid/ready channel interfaces for items, results and config writes
// depends on tssp_pkg for payload widths
`default_nettype none

interface tssp_item_if;
  logic                                  valid;
  logic                                  ready;
  logic [2:0]                            opcode;
  logic                                  servo_select;
  logic signed [tssp_pkg::WriteBits-1:0] write_value;
  logic                                  pwm_ticks;

  modport source (output valid, opcode, servo_select, write_value, pwm_ticks, input ready);
  modport sink   (input valid, opcode, servo_select, write_value, pwm_ticks, output ready);
endinterface

interface tssp_result_if;
  logic           valid;
  logic           ready;
  tssp_pkg::pos_t reply_value;
  tssp_pkg::pos_t position_a;
  tssp_pkg::pos_t position_b;
  logic           pwm_a;
  logic           pwm_b;

  modport source (output valid, reply_value, position_a, position_b, pwm_a, pwm_b,
                  input ready);
  modport sink   (input valid, reply_value, position_a, position_b, pwm_a, pwm_b,
                  output ready);
endinterface

interface tssp_cfg_if;
  logic               valid;
  logic               ready;
  tssp_pkg::cfg_idx_t index;
  tssp_pkg::pos_t     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/two_servo_scan_pwm.sv
// two_servo_scan_pwm: an item goes from the input register through execute into the result
// register; throughput one item per cycle while results are taken, with a single execute
// stage between the two registers; a held result stalls the input once both registers are full
// reset: config to min 0 / max all ones / offset 32, servo a at 0 sensing up,
// servo b at all ones sensing down, pwm counter 0, centers not yet captured
`default_nettype none

module two_servo_scan_pwm (
  input  logic          clk_i,
  input  logic          rst_ni,
  tssp_item_if.sink     in_i,
  tssp_cfg_if.sink      cfg_i,
  tssp_result_if.source out_o
);
  import tssp_pkg::*;

  // config registers
  cfg_t cfg;

  assign cfg_i.ready = 1'b1;

  tssp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  // input register stage
  item_t item_q;
  logic  item_vld_q;
  logic  out_vld_q;
  logic  advance;
  logic  in_ready;

  // item leaves the input register when the result register is free or drained
  assign advance  = item_vld_q && (!out_vld_q || out_o.ready);
  assign in_ready = !item_vld_q || advance;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_i.valid && in_ready) begin
      item_vld_q <= 1'b1;
    end else if (advance) begin
      item_vld_q <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      item_q.opcode       <= in_i.opcode;
      item_q.servo_select <= in_i.servo_select;
      item_q.write_value  <= in_i.write_value;
      item_q.pwm_ticks    <= in_i.pwm_ticks;
    end
  end

  // servo state, updated as each item passes the execute stage
  ctrl_state_t st_q, st_d;
  centers_t    ctr_q, ctr_d;
  result_t     res_q, res_d;

  tssp_exec u_exec (
    .item_i (item_q),
    .cfg_i  (cfg),
    .st_i   (st_q),
    .ctr_i  (ctr_q),
    .st_o   (st_d),
    .ctr_o  (ctr_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.pos_a         <= PosMin;
      st_q.pos_b         <= PosMax;
      st_q.sense_a_down  <= 1'b0;
      st_q.sense_b_down  <= 1'b1;
      st_q.centers_taken <= 1'b0;
      st_q.pwm_count     <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // centers only read once captured, so they carry no reset
  always_ff @(posedge clk_i) begin
    if (advance) begin
      ctr_q <= ctr_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.reply_value = res_q.reply_value;
  assign out_o.position_a  = res_q.position_a;
  assign out_o.position_b  = res_q.position_b;
  assign out_o.pwm_a       = res_q.pwm_a;
  assign out_o.pwm_b       = res_q.pwm_b;

  // servo state only moves when an item passes the execute stage
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(st_q.pos_a) && $stable(st_q.pos_b) && $stable(st_q.pwm_count))
    else $error("servo state changed without an item");

  // centers are captured once and never released
  a_centers_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.centers_taken |=> st_q.centers_taken)
    else $error("centers capture flag dropped");

  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_ready)
    else $error("input stalled with empty result register");

  // every executed item shows up as a result
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("executed item produced no result");

endmodule

`default_nettype wire

### src/tssp_cfg.sv
// tssp_cfg: configuration register file (limits and wave offset)
// depends on tssp_pkg
`default_nettype none

module tssp_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  tssp_pkg::cfg_idx_t wr_index_i,
  input  tssp_pkg::pos_t     wr_data_i,
  output tssp_pkg::cfg_t     cfg_o
);
  import tssp_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_index_i))
        CfgMinPos:  cfg_d.min_position = wr_data_i;
        CfgMaxPos:  cfg_d.max_position = wr_data_i;
        CfgWaveOff: cfg_d.wave_offset  = wr_data_i[OffsetBits-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_position <= PosMin;
      cfg_q.max_position <= PosMax;
      cfg_q.wave_offset  <= OffsetRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### src/tssp_exec.sv
// tssp_exec: combinational execution of one item against the servo state
// depends on tssp_pkg
`default_nettype none

module tssp_exec (
  input  tssp_pkg::item_t       item_i,
  input  tssp_pkg::cfg_t        cfg_i,
  input  tssp_pkg::ctrl_state_t st_i,
  input  tssp_pkg::centers_t    ctr_i,
  output tssp_pkg::ctrl_state_t st_o,
  output tssp_pkg::centers_t    ctr_o,
  output tssp_pkg::result_t     res_o
);
  import tssp_pkg::*;

  // signed width wide enough for the write value and a position plus sign
  localparam int unsigned CW = ((WriteBits > PositionBits + 1) ?
                                WriteBits : PositionBits + 1) + 1;
  localparam int unsigned WW = PositionBits + 2;

  function automatic pos_t clamp_w(logic signed [CW-1:0] v, pos_t mn, pos_t mx);
    logic signed [CW-1:0] smn;
    logic signed [CW-1:0] smx;
    smn = $signed({{(CW-PositionBits){1'b0}}, mn});
    smx = $signed({{(CW-PositionBits){1'b0}}, mx});
    if (v < smn)      return mn;
    else if (v > smx) return mx;
    else              return v[PositionBits-1:0];
  endfunction

  // one wave step of one servo: move, clamp, flip sense at the swing bounds
  function automatic logic [PositionBits:0] wave_one(pos_t pos, logic down, pos_t ctr,
                                                     cfg_t c);
    logic signed [CW-1:0] nxt;
    pos_t                 cur;
    logic signed [WW-1:0] cur_s;
    logic signed [WW-1:0] lo;
    logic signed [WW-1:0] hi;
    logic                 flip;
    nxt   = $signed({{(CW-PositionBits){1'b0}}, pos}) +
            (down ? -CW'(signed'(1)) : CW'(signed'(1)));
    cur   = clamp_w(nxt, c.min_position, c.max_position);
    cur_s = $signed({2'b00, cur});
    lo    = $signed({2'b00, ctr}) - $signed({3'b000, c.wave_offset});
    hi    = $signed({2'b00, ctr}) + $signed({3'b000, c.wave_offset});
    flip  = (cur_s <= lo) || (cur_s >= hi);
    return {down ^ flip, cur};
  endfunction

  logic                  sel_b;
  pos_t                  sel_pos;
  pos_t                  wr_pos;
  centers_t              ctr_use;
  logic [PositionBits:0] wa;
  logic [PositionBits:0] wb;

  always_comb begin
    sel_b   = item_i.servo_select;
    sel_pos = sel_b ? st_i.pos_b : st_i.pos_a;
    wr_pos  = clamp_w(CW'(item_i.write_value), cfg_i.min_position, cfg_i.max_position);
    ctr_use = st_i.centers_taken ? ctr_i :
              centers_t'{center_a: st_i.pos_a, center_b: st_i.pos_b};
    wa      = wave_one(st_i.pos_a, st_i.sense_a_down, ctr_use.center_a, cfg_i);
    wb      = wave_one(st_i.pos_b, st_i.sense_b_down, ctr_use.center_b, cfg_i);

    st_o  = st_i;
    ctr_o = ctr_i;
    res_o.reply_value = '0;

    case (item_i.opcode)
      OpRead: begin
        res_o.reply_value = sel_pos;
      end
      OpStepUp: begin
        // servo a is mounted inverted, so up lowers its position
        if (!sel_b) begin
          if (st_i.pos_a > cfg_i.min_position) st_o.pos_a = st_i.pos_a - 1'b1;
          res_o.reply_value = st_o.pos_a;
        end else begin
          if (st_i.pos_b < cfg_i.max_position) st_o.pos_b = st_i.pos_b + 1'b1;
          res_o.reply_value = st_o.pos_b;
        end
      end
      OpStepDown: begin
        if (!sel_b) begin
          if (st_i.pos_a < cfg_i.max_position) st_o.pos_a = st_i.pos_a + 1'b1;
          res_o.reply_value = st_o.pos_a;
        end else begin
          if (st_i.pos_b > cfg_i.min_position) st_o.pos_b = st_i.pos_b - 1'b1;
          res_o.reply_value = st_o.pos_b;
        end
      end
      OpWrite: begin
        res_o.reply_value = wr_pos;
        if (sel_b) st_o.pos_b = wr_pos;
        else       st_o.pos_a = wr_pos;
      end
      OpWave: begin
        ctr_o              = ctr_use;
        st_o.centers_taken = 1'b1;
        st_o.pos_a         = wa[PositionBits-1:0];
        st_o.sense_a_down  = wa[PositionBits];
        st_o.pos_b         = wb[PositionBits-1:0];
        st_o.sense_b_down  = wb[PositionBits];
      end
      default: begin
        res_o.reply_value = '0;
      end
    endcase

    if (item_i.pwm_ticks) st_o.pwm_count = st_i.pwm_count + 1'b1;

    res_o.position_a = st_o.pos_a;
    res_o.position_b = st_o.pos_b;
    res_o.pwm_a      = (st_o.pwm_count <= st_o.pos_a);
    res_o.pwm_b      = (st_o.pwm_count <= st_o.pos_b);
  end

endmodule

`default_nettype wire

### bench/tb.sv
// tb: self-checking testbench for the two servo scan pwm block
// depends on tssp_pkg, the tssp_*_if interfaces and two_servo_scan_pwm
`timescale 1ns / 100ps

module tb;
  import tssp_pkg::*;

  localparam int NumPhases     = 7;
  localparam int PhaseItems    = 150;
  localparam int HoldOffCycles = 300;
  localparam int QuietLimit    = 2000;

  // opcodes the block leaves undefined, and the config index with no register
  localparam logic [2:0] OpSpare5 = 3'd5;
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;
  localparam cfg_idx_t   CfgSpare = 2'd3;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tssp_item_if   item_ch ();
  tssp_cfg_if    cfg_ch ();
  tssp_result_if res_ch ();

  two_servo_scan_pwm DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_ch),
    .cfg_i  (cfg_ch),
    .out_o  (res_ch)
  );

  // shadow copy of the servo controller: config and state
  pos_t lim_min, lim_max;
  off_t swing;
  pos_t servo_a, servo_b, center_a, center_b, pwm_cnt;
  logic a_down, b_down, centers_held;

  result_t   pending_replies [$];
  stim_row_t directed_rows [$];

  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_req = 0;
  int   hold_done = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  pos_t phase_min [NumPhases] = '{10'd0, 10'd100, 10'd600, 10'd0, 10'd1023, 10'd0, 10'd0};
  pos_t phase_max [NumPhases] = '{10'd1023, 10'd900, 10'd300, 10'd1023, 10'd1023, 10'd0,
                                  10'd0};
  pos_t phase_off [NumPhases] = '{10'd32, 10'd200, 10'd5, 10'h3ff, 10'd0, 10'd1, 10'd0};

  function automatic pos_t clamp_to_limits(input int v);
    if (v < int'(lim_min)) return lim_min;
    if (v > int'(lim_max)) return lim_max;
    return pos_t'(v);
  endfunction

  // one servo's share of a wave step; bounds are plain integers, no wrap
  task automatic wave_move(inout pos_t p, inout logic down, input pos_t ctr);
    int nxt;
    int cur;
    nxt = int'(p) + (down ? -1 : 1);
    p = clamp_to_limits(nxt);
    cur = int'(p);
    if (cur <= int'(ctr) - int'(swing) || cur >= int'(ctr) + int'(swing)) down = ~down;
  endtask

  // advance the shadow state by one item and form the reply it causes
  task automatic predict_servo(input item_t it, output result_t r);
    int   wv;
    pos_t reply;
    wv = $signed(it.write_value);
    reply = '0;
    case (it.opcode)
      OpRead: begin
        reply = it.servo_select ? servo_b : servo_a;
      end
      OpStepUp: begin
        // servo a is mounted inverted: up means a lower position
        if (!it.servo_select) begin
          if (servo_a > lim_min) servo_a = servo_a - 1'b1;
        end else if (servo_b < lim_max) begin
          servo_b = servo_b + 1'b1;
        end
        reply = it.servo_select ? servo_b : servo_a;
      end
      OpStepDown: begin
        if (!it.servo_select) begin
          if (servo_a < lim_max) servo_a = servo_a + 1'b1;
        end else if (servo_b > lim_min) begin
          servo_b = servo_b - 1'b1;
        end
        reply = it.servo_select ? servo_b : servo_a;
      end
      OpWrite: begin
        reply = clamp_to_limits(wv);
        if (it.servo_select) servo_b = reply;
        else servo_a = reply;
      end
      OpWave: begin
        if (!centers_held) begin
          center_a = servo_a;
          center_b = servo_b;
          centers_held = 1'b1;
        end
        wave_move(servo_a, a_down, center_a);
        wave_move(servo_b, b_down, center_b);
      end
      default: begin
        reply = '0;
      end
    endcase
    if (it.pwm_ticks) pwm_cnt = pwm_cnt + 1'b1;
    r.reply_value = reply;
    r.position_a  = servo_a;
    r.position_b  = servo_b;
    r.pwm_a       = (pwm_cnt <= servo_a);
    r.pwm_b       = (pwm_cnt <= servo_b);
  endtask

  function automatic void add_row(input logic [2:0] op, input logic sel, input int wv,
                                  input logic tick, input bit typed, input result_t res);
    stim_row_t row;
    row.it.opcode       = op;
    row.it.servo_select = sel;
    row.it.write_value  = 16'(wv);
    row.it.pwm_ticks    = tick;
    row.typed           = typed;
    row.res             = res;
    directed_rows.push_back(row);
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 15) it.opcode = OpRead;
    else if (r < 35) it.opcode = OpStepUp;
    else if (r < 55) it.opcode = OpStepDown;
    else if (r < 74) it.opcode = OpWrite;
    else if (r < 94) it.opcode = OpWave;
    else it.opcode = 3'($urandom_range(OpSpare5, OpSpare7));
    it.servo_select = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 9);
    // mostly in range, some right at the limits, some anywhere in 16 bits
    if (r < 5) it.write_value = 16'($urandom_range(0, 1023));
    else if (r < 7) it.write_value = 16'(int'(lim_min) + int'($urandom_range(0, 4)) - 2);
    else if (r < 8) it.write_value = 16'(int'(lim_max) + int'($urandom_range(0, 4)) - 2);
    else it.write_value = 16'($urandom);
    // ticks nearly every item so the pwm counter wraps during the run
    it.pwm_ticks = ($urandom_range(0, 99) < 95);
    return it;
  endfunction

  // offer one item, wait for its transaction, then queue what it should produce
  task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
    result_t r;
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_ch.valid        <= 1'b1;
    item_ch.opcode       <= it.opcode;
    item_ch.servo_select <= it.servo_select;
    item_ch.write_value  <= it.write_value;
    item_ch.pwm_ticks    <= it.pwm_ticks;
    do @(posedge clk_i); while (!item_ch.ready);
    predict_servo(it, r);
    pending_replies.push_back(typed ? typed_res : r);
  endtask

  // stop offering and wait until every queued reply has come back
  task automatic settle_block(input int extra);
    @(negedge clk_i);
    item_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input pos_t data);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CfgMinPos:  lim_min = data;
      CfgMaxPos:  lim_max = data;
      CfgWaveOff: swing = data[OffsetBits-1:0];
      default:    ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // receiver: random ready, plus one long hold-off when the sender asks for it
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else if (hold_req != hold_done) begin
      hold_done++;
      hold_left = HoldOffCycles;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // result transactions against the oldest queued reply
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, reply %0d", $time, res_ch.reply_value);
      end else begin
        want = pending_replies.pop_front();
        check_field("reply_value", want.reply_value, res_ch.reply_value);
        check_field("position_a", want.position_a, res_ch.position_a);
        check_field("position_b", want.position_b, res_ch.position_b);
        check_field("pwm_a", want.pwm_a, res_ch.pwm_a);
        check_field("pwm_b", want.pwm_b, res_ch.pwm_b);
      end
    end
  end

  // watchdog on cycles in which no channel moves a transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    item_t it;
    int    count;
    int    burst;
    bit    held;
    bit    paused;

    item_ch.valid        = 1'b0;
    item_ch.opcode       = '0;
    item_ch.servo_select = 1'b0;
    item_ch.write_value  = '0;
    item_ch.pwm_ticks    = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    res_ch.ready         = 1'b0;

    lim_min      = PosMin;
    lim_max      = PosMax;
    swing        = OffsetRst;
    servo_a      = PosMin;
    servo_b      = PosMax;
    a_down       = 1'b0;
    b_down       = 1'b1;
    center_a     = '0;
    center_b     = '0;
    centers_held = 1'b0;
    pwm_cnt      = '0;
    held         = 1'b0;
    paused       = 1'b0;

    // reset state rows, then extremes and every opcode; the first wave step
    // captures centers 0 and all ones, so the low bound of a and high bound of b fall outside the range
    add_row(OpRead, 1'b0, 0, 1'b0, 1'b1, result_t'{10'd0, 10'd0, 10'd1023, 1'b1, 1'b1});
    add_row(OpRead, 1'b1, 0, 1'b0, 1'b1, result_t'{10'd1023, 10'd0, 10'd1023, 1'b1, 1'b1});
    add_row(OpStepUp, 1'b0, 0, 1'b0, 1'b1, result_t'{10'd0, 10'd0, 10'd1023, 1'b1, 1'b1});
    add_row(OpStepUp, 1'b1, 0, 1'b0, 1'b1, result_t'{10'd1023, 10'd0, 10'd1023, 1'b1, 1'b1});
    add_row(OpWave, 1'b0, 0, 1'b0, 1'b1, result_t'{10'd0, 10'd1, 10'd1022, 1'b1, 1'b1});
    add_row(OpWave, 1'b1, -1, 1'b1, 1'b0, '0);
    add_row(OpWrite, 1'b0, 32767, 1'b1, 1'b0, '0);
    add_row(OpWrite, 1'b1, -32768, 1'b1, 1'b0, '0);
    add_row(OpStepDown, 1'b0, 0, 1'b0, 1'b0, '0);
    add_row(OpStepDown, 1'b1, 0, 1'b0, 1'b0, '0);
    add_row(OpStepUp, 1'b0, 0, 1'b1, 1'b0, '0);
    add_row(OpStepUp, 1'b1, 0, 1'b1, 1'b0, '0);
    add_row(OpWrite, 1'b0, -1, 1'b0, 1'b0, '0);
    add_row(OpWrite, 1'b1, 1024, 1'b0, 1'b0, '0);
    add_row(OpWrite, 1'b0, 1023, 1'b1, 1'b0, '0);
    add_row(OpWrite, 1'b1, 512, 1'b1, 1'b0, '0);
    add_row(OpStepDown, 1'b1, 0, 1'b1, 1'b0, '0);
    add_row(OpRead, 1'b0, 16'h5555, 1'b1, 1'b0, '0);
    add_row(OpSpare5, 1'b1, 16'haaaa, 1'b1, 1'b0, '0);
    add_row(OpSpare6, 1'b0, 0, 1'b1, 1'b0, '0);
    add_row(OpSpare7, 1'b1, 32767, 1'b0, 1'b0, '0);
    add_row(OpWave, 1'b0, 0, 1'b1, 1'b0, '0);
    add_row(OpWave, 1'b1, 0, 1'b1, 1'b0, '0);
    add_row(OpRead, 1'b1, 0, 1'b1, 1'b0, '0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < NumPhases; ph++) begin
      // sender idles 36 / receiver 57, then swapped, then no idling
      if (ph < 3) begin
        send_idle_pct = 36;
        recv_idle_pct = 57;
      end else if (ph < 5) begin
        send_idle_pct = 57;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (ph == 0) begin
        foreach (directed_rows[i])
          send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);
      end else begin
        settle_block(4);
        if (ph == NumPhases - 1) begin
          phase_min[ph] = pos_t'($urandom_range(0, 1023));
          phase_max[ph] = pos_t'($urandom_range(0, 1023));
          phase_off[ph] = pos_t'($urandom_range(0, 1023));
        end
        cfg_write(CfgMinPos, phase_min[ph]);
        cfg_write(CfgMaxPos, phase_max[ph]);
        cfg_write(CfgWaveOff, phase_off[ph]);
        if (ph == 2) cfg_write(CfgSpare, pos_t'($urandom_range(0, 1023)));
      end

      count = 0;
      while (count < PhaseItems) begin
        // long receiver hold-off while items keep coming, so the input stalls
        if (ph == 1 && !held && count >= 40) begin
          held = 1'b1;
          hold_req++;
        end
        // one full pause of the sender until every reply is in
        if (ph == 4 && !paused && count >= 60) begin
          paused = 1'b1;
          settle_block(0);
        end
        if ($urandom_range(0, 9) == 0) begin
          // run of wave steps so the sense flips at both bounds
          burst = $urandom_range(8, 40);
          repeat (burst) begin
            it = random_item();
            it.opcode = OpWave;
            send_item(it, 1'b0, '0);
          end
          count += burst;
        end else begin
          send_item(random_item(), 1'b0, '0);
          count++;
        end
      end
    end

    settle_block(10);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
